// ===== src/gtbd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtbd_pkg: shared types and constants for the graph traversal block
// Request layouts, action and status codes, controller/datapath links.
// ----------------------------------------------------------------------------
package gtbd_pkg;

    localparam int DEF_MAX_NODES  = 32;
    localparam int DEF_MAX_DEGREE = 8;
    localparam int NODE_W         = 5;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 6;

    localparam logic [CFG_IDX_W-1:0] REG_MODE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT = 1'd1;

    localparam logic [1:0] ACT_ADD   = 2'd0;
    localparam logic [1:0] ACT_TRAV  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    localparam logic [1:0] ST_VISIT = 2'd0;
    localparam logic [1:0] ST_OK    = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic [1:0]        action;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
    } req_t;

    typedef struct packed {
        logic [NODE_W-1:0] visited_node;
        logic [1:0]        status;
        logic              last;
    } rsp_t;

    // controller -> datapath commands
    typedef struct packed {
        logic load;        // capture request
        logic clear;       // empty lists
        logic add_write;   // commit edge
        logic trav_init;   // clear marks, seed work list at start
        logic step_issue;  // read next neighbor slot (launch table read)
        logic step_eval;   // evaluate registered neighbor
        logic pop;         // dfs pop / bfs advance head
        logic emit_node;   // result carries a node
        logic out_load;    // load output register
        logic out_last;
        logic [1:0] out_status;
    } cmd_t;

    // datapath -> controller status
    typedef struct packed {
        logic [1:0] action;
        logic       range_err;
        logic       full_err;
        logic       have_slot;   // current node has unread neighbor
        logic       list_empty;  // no work left after the current node
        logic       take;        // evaluated neighbor is newly visited
        logic       out_busy;
    } stat_t;

endpackage

// ===== src/gtbd_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtbd_datapath: graph storage and traversal datapath
// Holds adjacency memory, degrees, visit marks, work list and output register.
// ----------------------------------------------------------------------------
module gtbd_datapath #(
    parameter int MAX_NODES  = gtbd_pkg::DEF_MAX_NODES,
    parameter int MAX_DEGREE = gtbd_pkg::DEF_MAX_DEGREE
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  gtbd_pkg::req_t                   req,
    input  logic                             cfg_we,
    input  logic [gtbd_pkg::CFG_IDX_W-1:0]   cfg_idx,
    input  logic [gtbd_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  gtbd_pkg::cmd_t                   cmd,
    output gtbd_pkg::stat_t                  stat,
    input  logic                             out_stall,
    output logic                             out_valid,
    output gtbd_pkg::rsp_t                   rsp
);
    import gtbd_pkg::*;

    localparam int NW    = $clog2(MAX_NODES);
    localparam int DW    = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
    localparam int DCW   = $clog2(MAX_DEGREE + 1);
    localparam int CW    = $clog2(MAX_NODES + 1);
    localparam int AW    = NW + DW;
    localparam int SLOTS = 1 << DW;

    logic [NW-1:0]  nbr_mem [MAX_NODES*SLOTS];
    logic [NW-1:0]  wl_mem  [MAX_NODES];
    logic [DCW-1:0] sp_mem  [MAX_NODES];
    logic [DCW-1:0] deg_reg [MAX_NODES];
    logic [MAX_NODES-1:0] mark_reg;

    logic           mode_reg;
    logic [CW-1:0]  count_reg;
    req_t           req_reg;
    logic [CW-1:0]  head_reg, tail_reg;
    logic [NW-1:0]  cur_reg;       // node being expanded
    logic [DCW-1:0] pos_reg;       // its next slot
    logic [NW-1:0]  nb_reg;        // registered neighbor read
    logic [NW-1:0]  pend_node_reg; // latest visit, held until the next is known
    logic           out_valid_reg;
    rsp_t           rsp_reg;

    logic          bw_pend_reg;
    logic [AW-1:0] bw_addr_reg;
    logic [NW-1:0] bw_data_reg;
    logic [AW-1:0] rd_addr;

    logic [NW-1:0] a_n, b_n;
    logic [CW-1:0] cfg_v;
    logic          self_loop, a_full, b_full;

    assign a_n = req_reg.node_a[NW-1:0];
    assign b_n = req_reg.node_b[NW-1:0];
    assign self_loop = (req_reg.node_a == req_reg.node_b);
    assign a_full = self_loop
        ? (({1'b0, deg_reg[a_n]} + (DCW+1)'(2)) > (DCW+1)'(MAX_DEGREE))
        : (deg_reg[a_n] >= DCW'(MAX_DEGREE));
    assign b_full = (deg_reg[b_n] >= DCW'(MAX_DEGREE));

    always_comb
    begin
        cfg_v = (cfg_data > CFG_DATA_W'(MAX_NODES)) ? CW'(MAX_NODES)
              : (cfg_data == '0) ? CW'(1) : CW'(cfg_data);
    end

    assign stat.action    = req_reg.action;
    assign stat.range_err = (req_reg.action == ACT_TRAV)
        ? ({1'b0, req_reg.node_a} >= (NODE_W+1)'(count_reg))
        : ({1'b0, req_reg.node_a} >= (NODE_W+1)'(count_reg)
           || {1'b0, req_reg.node_b} >= (NODE_W+1)'(count_reg));
    assign stat.full_err  = a_full || b_full;
    assign stat.have_slot = (pos_reg < deg_reg[cur_reg]);
    assign stat.list_empty = mode_reg ? (tail_reg == CW'(1)) : (head_reg == tail_reg);
    assign stat.take = ({1'b0, nb_reg} < (NW+1)'(count_reg)) && !mark_reg[nb_reg]
                       && (tail_reg < CW'(MAX_NODES));
    assign stat.out_busy  = out_valid_reg && out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= 1'b0;
            count_reg     <= CW'(MAX_NODES);
            mark_reg      <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_NODES; i++)
                deg_reg[i] <= '0;
        end
        else
        begin
            if (cfg_we && cfg_idx == REG_MODE)
                mode_reg <= cfg_data[0];
            if (cfg_we && cfg_idx == REG_COUNT)
                count_reg <= cfg_v;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            if (cmd.clear)
            begin
                mark_reg <= '0;
                head_reg <= '0;
                tail_reg <= '0;
                for (int i = 0; i < MAX_NODES; i++)
                    deg_reg[i] <= '0;
            end
            if (cmd.add_write)
            begin
                if (self_loop)
                    deg_reg[a_n] <= deg_reg[a_n] + DCW'(2);
                else
                begin
                    deg_reg[a_n] <= deg_reg[a_n] + DCW'(1);
                    deg_reg[b_n] <= deg_reg[b_n] + DCW'(1);
                end
            end
            if (cmd.trav_init)
            begin
                mark_reg <= {{(MAX_NODES-1){1'b0}}, 1'b1} << a_n;
                head_reg <= mode_reg ? '0 : CW'(1);
                tail_reg <= CW'(1);
            end
            if (cmd.step_eval && stat.take)
            begin
                mark_reg[nb_reg] <= 1'b1;
                tail_reg <= tail_reg + CW'(1);
            end
            if (cmd.pop)
            begin
                if (mode_reg)
                    tail_reg <= tail_reg - CW'(1);
                else
                    head_reg <= head_reg + CW'(1);
            end
        end
    end

    // adjacency memory: one write per cycle, so the second endpoint of an
    // edge is written on the cycle after the first
    assign rd_addr = {cur_reg, pos_reg[DW-1:0]};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            req_reg <= req;
        if (cmd.add_write)
        begin
            nbr_mem[{a_n, deg_reg[a_n][DW-1:0]}] <= b_n;
            bw_addr_reg <= self_loop ? {a_n, DW'(deg_reg[a_n] + DCW'(1))}
                                     : {b_n, deg_reg[b_n][DW-1:0]};
            bw_data_reg <= a_n;
        end
        if (bw_pend_reg)
            nbr_mem[bw_addr_reg] <= bw_data_reg;
        if (cmd.step_issue)
        begin
            nb_reg  <= nbr_mem[rd_addr];
            pos_reg <= pos_reg + DCW'(1);
        end
        if (cmd.trav_init)
        begin
            cur_reg       <= a_n;
            pos_reg       <= '0;
            pend_node_reg <= a_n;
            wl_mem[0]     <= a_n;
            sp_mem[0]     <= '0;
        end
        if (cmd.step_eval && stat.take)
        begin
            pend_node_reg <= nb_reg;
            wl_mem[tail_reg[NW-1:0]] <= nb_reg;
            if (mode_reg)
            begin
                sp_mem[tail_reg[NW-1:0] - NW'(1)] <= pos_reg;
                cur_reg <= nb_reg;
                pos_reg <= '0;
            end
        end
        if (cmd.pop)
        begin
            if (mode_reg)
            begin
                cur_reg <= wl_mem[tail_reg[NW-1:0] - NW'(2)];
                pos_reg <= sp_mem[tail_reg[NW-1:0] - NW'(2)];
            end
            else
            begin
                cur_reg <= wl_mem[head_reg[NW-1:0]];
                pos_reg <= '0;
            end
        end
        if (cmd.out_load)
        begin
            rsp_reg.visited_node <= cmd.emit_node ? NODE_W'(pend_node_reg) : '0;
            rsp_reg.status <= cmd.out_status;
            rsp_reg.last   <= cmd.out_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bw_pend_reg <= 1'b0;
        else
            bw_pend_reg <= cmd.add_write;
    end

    assign out_valid = out_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== src/gtbd_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtbd_ctrl: traversal sequencer
// Steps each request through decode, edge write and neighbor scan.
// ----------------------------------------------------------------------------
module gtbd_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  gtbd_pkg::stat_t stat,
    output gtbd_pkg::cmd_t  cmd
);
    import gtbd_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DEC    = 3'd1;
    localparam logic [2:0] S_WB     = 3'd2;
    localparam logic [2:0] S_ISSUE  = 3'd3;
    localparam logic [2:0] S_EVAL   = 3'd4;
    localparam logic [2:0] S_POP    = 3'd5;

    logic [2:0] state_reg, state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                if (!stat.out_busy)
                begin
                    case (stat.action)
                        ACT_ADD:
                        begin
                            cmd.out_load   = 1'b1;
                            cmd.out_last   = 1'b1;
                            cmd.out_status = stat.range_err ? ST_RANGE
                                           : stat.full_err ? ST_FULL : ST_OK;
                            cmd.add_write  = !stat.range_err && !stat.full_err;
                            state_next     = cmd.add_write ? S_WB : S_IDLE;
                        end
                        ACT_CLEAR:
                        begin
                            cmd.clear      = 1'b1;
                            cmd.out_load   = 1'b1;
                            cmd.out_last   = 1'b1;
                            cmd.out_status = ST_OK;
                            state_next     = S_IDLE;
                        end
                        ACT_TRAV:
                        begin
                            if (stat.range_err)
                            begin
                                cmd.out_load   = 1'b1;
                                cmd.out_last   = 1'b1;
                                cmd.out_status = ST_RANGE;
                                state_next     = S_IDLE;
                            end
                            else
                            begin
                                cmd.trav_init = 1'b1;
                                state_next    = S_ISSUE;
                            end
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_WB: state_next = S_IDLE;
            S_ISSUE:
            begin
                if (stat.have_slot)
                begin
                    cmd.step_issue = 1'b1;
                    state_next     = S_EVAL;
                end
                else
                    state_next = S_POP;
            end
            S_EVAL:
            begin
                // a new visit releases the held one as a non-final result
                if (!stat.out_busy)
                begin
                    cmd.step_eval  = 1'b1;
                    cmd.out_load   = stat.take;
                    cmd.emit_node  = 1'b1;
                    cmd.out_status = ST_VISIT;
                    state_next     = S_ISSUE;
                end
            end
            S_POP:
            begin
                if (!stat.list_empty)
                begin
                    cmd.pop    = 1'b1;
                    state_next = S_ISSUE;
                end
                else if (!stat.out_busy)
                begin
                    // no work left: the held visit is the final result
                    cmd.out_load   = 1'b1;
                    cmd.emit_node  = 1'b1;
                    cmd.out_last   = 1'b1;
                    cmd.out_status = ST_VISIT;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== src/graph_traversal_bfs_dfs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// graph_traversal_bfs_dfs: adjacency-list graph with BFS/DFS traversal
// Sequencer plus datapath; one request in flight at a time.
// ----------------------------------------------------------------------------
// channel | direction | handshake
// in      | input     | in_valid / in_stall, payload in_req
// out     | output    | out_valid / out_stall, payload out_rsp
// cfg     | input     | cfg_we, cfg_idx, cfg_data
//
// A request is taken only when the sequencer is idle. Add edge and clear hold
//   the input through the decode state, and a stored edge also through the
//   write-back state. A traversal issues and then evaluates each adjacency
//   slot of every visited node in turn, popping the work list between nodes.
// Reset: rst_n clears degrees, visit marks, mode (breadth-first) and node
//   count (MAX_NODES); adjacency contents are left as they are.
// Stalls: out_stall holds the output register; the sequencer waits before
//   loading the next result, so a stalled output stretches the request.
//
module graph_traversal_bfs_dfs #(
    parameter int MAX_NODES  = gtbd_pkg::DEF_MAX_NODES,
    parameter int MAX_DEGREE = gtbd_pkg::DEF_MAX_DEGREE
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  gtbd_pkg::req_t                  in_req,
    output logic                            out_valid,
    input  logic                            out_stall,
    output gtbd_pkg::rsp_t                  out_rsp,
    input  logic                            cfg_we,
    input  logic [gtbd_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [gtbd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import gtbd_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    gtbd_ctrl u_ctrl (
        .clk, .rst_n, .in_valid, .in_stall, .stat, .cmd
    );

    gtbd_datapath #(.MAX_NODES(MAX_NODES), .MAX_DEGREE(MAX_DEGREE)) u_dp (
        .clk, .rst_n, .req(in_req), .cfg_we, .cfg_idx, .cfg_data,
        .cmd, .stat, .out_stall, .out_valid, .rsp(out_rsp)
    );

    // hold a stalled result unchanged
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_rsp));

    // a presented result is fully defined
    a_out_known: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !$isunknown(out_rsp));

    // an accepted request keeps the input stalled on the next cycle
    a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall);

endmodule
